/* hw/rtl/pik_pkg.sv */
// ----------------------------------------------------------------------------
// pik_pkg
// Shared constants and the CORDIC arctangent table for the panel influence
// kernel.
// ----------------------------------------------------------------------------
package pik_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int PRE_SHIFT        = 12;
    localparam int ANG_W            = 36;
    localparam int LN_W             = 40;
    localparam int SPLIT            = 20;
    localparam int LN_LAT           = 34;

    localparam logic signed [ANG_W-1:0] ANG_PI = 36'sd3373259426;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [29:0] LNK_Q30    = 30'd535593028;
    localparam logic [29:0] INV2PI_Q31 = 30'd341782638;

    function automatic logic [29:0] atan_q30(input int k);
        logic [29:0] r;
        case (k)
            0:       r = 30'h3243F6A8;
            1:       r = 30'h1DAC6705;
            2:       r = 30'h0FADBAFC;
            3:       r = 30'h07F56EA6;
            4:       r = 30'h03FEAB76;
            5:       r = 30'h01FFD55B;
            6:       r = 30'h00FFFAAA;
            7:       r = 30'h007FFF55;
            8:       r = 30'h003FFFEA;
            9:       r = 30'h001FFFFD;
            10:      r = 30'h000FFFFF;
            11:      r = 30'h0007FFFF;
            12:      r = 30'h0003FFFF;
            13:      r = 30'h0001FFFF;
            14:      r = 30'h0000FFFF;
            15:      r = 30'h00007FFF;
            16:      r = 30'h00003FFF;
            17:      r = 30'h00001FFF;
            18:      r = 30'h00000FFF;
            19:      r = 30'h000007FF;
            20:      r = 30'h000003FF;
            21:      r = 30'h000001FF;
            22:      r = 30'h000000FF;
            23:      r = 30'h0000007F;
            24:      r = 30'h0000003F;
            25:      r = 30'h0000001F;
            26:      r = 30'h0000000F;
            27:      r = 30'h00000007;
            28:      r = 30'h00000003;
            29:      r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/pik_cordic.sv */
// ----------------------------------------------------------------------------
// pik_cordic
// Pipelined CORDIC vectoring unit: one micro-rotation per register stage,
// giving the angle in Q30 radians and the scaled magnitude.
// ----------------------------------------------------------------------------
module pik_cordic #(
    parameter int IN_W  = 49,
    parameter int STEPS = pik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic signed [IN_W-1:0]           i_x,
    input  logic signed [IN_W-1:0]           i_y,
    output logic signed [pik_pkg::ANG_W-1:0] o_ang,
    output logic [IN_W+1:0]                  o_mag
);
    import pik_pkg::*;

    localparam int CW = IN_W + 2;

    logic signed [CW-1:0]    r_x [0:STEPS];
    logic signed [CW-1:0]    r_y [0:STEPS];
    logic signed [ANG_W-1:0] r_z [0:STEPS];

    logic signed [CW-1:0]    n_x0;
    logic signed [CW-1:0]    n_y0;
    logic signed [ANG_W-1:0] n_z0;

    // A vector in the left half plane is turned by pi first.
    always_comb begin
        n_x0 = CW'(i_x);
        n_y0 = CW'(i_y);
        n_z0 = '0;
        if (i_x < 0) begin
            n_z0 = (i_y >= 0) ? ANG_PI : -ANG_PI;
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= n_x0;
        r_y[0] <= n_y0;
        r_z[0] <= n_z0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CW-1:0]    n_x;
        logic signed [CW-1:0]    n_y;
        logic signed [ANG_W-1:0] n_z;
        logic signed [ANG_W-1:0] w_at;

        assign w_at = $signed(ANG_W'(atan_q30(i)));

        always_comb begin
            n_x = r_x[i];
            n_y = r_y[i];
            n_z = r_z[i];
            if (r_y[i] > 0) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + w_at;
            end else if (r_y[i] < 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1] <= n_x;
            r_y[i+1] <= n_y;
            r_z[i+1] <= n_z;
        end
    end

    assign o_ang = r_z[STEPS];
    assign o_mag = r_x[STEPS];

endmodule

/* hw/rtl/pik_ln.sv */
// ----------------------------------------------------------------------------
// pik_ln
// Pipelined natural log of the CORDIC magnitude, returned as ln of the true
// radius in Q30: leading-one search, normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
module pik_ln #(
    parameter int MAG_W     = 51,
    parameter int FRAC_BITS = pik_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic [MAG_W-1:0]                i_mag,
    output logic signed [pik_pkg::LN_W-1:0] o_lnr
);
    import pik_pkg::*;

    localparam int NB = $clog2(MAG_W);
    localparam int SQ = 30;
    localparam longint LN_OFS_L = longint'(FRAC_BITS + PRE_SHIFT) * longint'(LN2_Q30)
                                  + longint'(LNK_Q30);
    localparam logic signed [LN_W-1:0] LN_OFS = LN_W'(LN_OFS_L);

    logic [NB-1:0]    n_msb;
    logic [MAG_W-1:0] r_a_mag;
    logic [NB-1:0]    r_a_msb;
    logic             r_a_zero;
    logic [MAG_W-1:0] n_norm;

    logic [30:0]      r_m    [0:SQ];
    logic [29:0]      r_f    [0:SQ];
    logic [NB-1:0]    r_msb  [0:SQ];
    logic             r_zero [0:SQ];

    logic [60:0]      r_c_prod;
    logic [NB+29:0]   r_c_nl;
    logic             r_c_zero;
    logic signed [LN_W-1:0] n_lnq;
    logic signed [LN_W-1:0] r_lnr;

    always_comb begin
        n_msb = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (i_mag[b]) n_msb = NB'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= i_mag;
        r_a_msb  <= n_msb;
        r_a_zero <= (i_mag == '0);
    end

    // Bring the leading one to the top, then keep 31 bits as a Q30 mantissa.
    assign n_norm = r_a_mag << (NB'(MAG_W - 1) - r_a_msb);

    always_ff @(posedge i_clk) begin
        r_m[0]    <= n_norm[MAG_W-1 -: 31];
        r_f[0]    <= '0;
        r_msb[0]  <= r_a_msb;
        r_zero[0] <= r_a_zero;
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_t;

        assign w_sq = 62'(r_m[j]) * 62'(r_m[j]);
        assign w_t  = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            r_m[j+1]    <= w_t[31] ? w_t[31:1] : w_t[30:0];
            r_f[j+1]    <= {r_f[j][28:0], w_t[31]};
            r_msb[j+1]  <= r_msb[j];
            r_zero[j+1] <= r_zero[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_prod <= 61'(r_f[SQ]) * 61'(LN2_Q30) + (61'(1) << 29);
        r_c_nl   <= (NB+30)'(r_msb[SQ]) * (NB+30)'(LN2_Q30);
        r_c_zero <= r_zero[SQ];
    end

    assign n_lnq = $signed(LN_W'(r_c_nl)) + $signed(LN_W'(r_c_prod[60:30]));

    // The log of a zero magnitude is taken as zero before the offset.
    always_ff @(posedge i_clk) begin
        r_lnr <= r_c_zero ? -LN_OFS : n_lnq - LN_OFS;
    end

    assign o_lnr = r_lnr;

endmodule

/* hw/rtl/panel_influence_kernel.sv */
// ----------------------------------------------------------------------------
// panel_influence_kernel
// 2D Laplace single- and double-layer influence of a constant-strength
// straight panel on one query point, fully pipelined.
// ----------------------------------------------------------------------------
// The delay from start to o_valid is mostly set by the CORDIC rotations and
// the 30 squaring stages of the log. Throughput: one item per cycle; busy is
// always low and the pipeline never stalls. Each result is shown for one
// cycle with o_valid.
// Reset clears only the valid pipeline; the data path needs no reset.
module panel_influence_kernel #(
    parameter int FRAC_BITS    = pik_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = pik_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    input  logic signed [31:0] i_mid_x,
    input  logic signed [31:0] i_mid_y,
    input  logic signed [17:0] i_normal_x,
    input  logic signed [17:0] i_normal_y,
    input  logic [30:0]        i_panel_length,
    output logic               o_valid,
    output logic signed [31:0] o_single_layer,
    output logic signed [31:0] o_double_layer,
    output logic               o_overflow
);
    import pik_pkg::*;

    localparam int DW   = 52 - FRAC_BITS;
    localparam int UW   = ((DW > 31) ? DW : 31) + 1;
    localparam int XW   = UW + PRE_SHIFT;
    localparam int MW   = XW + 2;
    localparam int LC   = CORDIC_STEPS + 1;
    localparam int LD   = LC + LN_LAT;
    localparam int LAT  = 12 + LD;
    localparam int AW1  = ANG_W + 1;
    localparam int NW   = UW + LN_W + 3;
    localparam int VW   = NW - 30;
    localparam int P0LW = DW + SPLIT + 1;
    localparam int P0HW = DW + AW1 - SPLIT;
    localparam int P1LW = UW + SPLIT + 1;
    localparam int P1HW = UW + LN_W - SPLIT;
    localparam int DDW  = AW1 + 32;
    localparam logic signed [VW-1:0] V_LIM = VW'(longint'(1) <<< 34);
    localparam logic signed [35:0] S_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S_MIN = -36'sd2147483648;

    logic [LAT-1:0] r_vld;

    // Front end: panel frame.
    logic signed [32:0]   r_dx, r_dy;
    logic signed [17:0]   r_nx, r_ny;
    logic [29:0]          r_h1, r_h2, r_h3;
    logic signed [50:0]   r_p1, r_p2, r_p3, r_p4;
    logic signed [DW-1:0] r_dlt3, r_dlt4;
    logic signed [UW-1:0] r_s0, r_u1, r_u2;

    logic signed [ANG_W-1:0] w_a1, w_a2;
    logic [MW-1:0]           w_m1, w_m2;
    logic signed [LN_W-1:0]  w_l1, w_l2;

    logic signed [DW-1:0]    r_d_dlt [0:LD-1];
    logic signed [UW-1:0]    r_d_u1  [0:LD-1];
    logic signed [UW-1:0]    r_d_u2  [0:LD-1];
    logic signed [ANG_W-1:0] r_d_a1  [0:LN_LAT-1];
    logic signed [ANG_W-1:0] r_d_a2  [0:LN_LAT-1];

    // Back end.
    logic signed [AW1-1:0]  r_diff, r_ndiff;
    logic signed [UW:0]     r_ud5, r_ud6;
    logic signed [DW-1:0]   r_dlt5;
    logic signed [UW-1:0]   r_u15, r_u25;
    logic signed [LN_W-1:0] r_l15, r_l25;
    logic signed [P0LW-1:0] r_p0l;
    logic signed [P0HW-1:0] r_p0h;
    logic signed [P1LW-1:0] r_p1l, r_p2l;
    logic signed [P1HW-1:0] r_p1h, r_p2h;
    logic signed [DDW-1:0]  r_dd;
    logic signed [NW-1:0]   r_m0, r_m1, r_m2, r_t, r_sa, r_sb, r_n;
    logic signed [DDW-1:0]  n_dsum;
    logic signed [DDW-1:0]  n_dl;
    logic signed [31:0]     n_dl32;
    logic signed [31:0]     r_dl7, r_dl8, r_dl9, r_dl10, r_dl11;
    logic signed [VW-1:0]   n_v;
    logic signed [35:0]     r_v;
    logic                   r_big10, r_neg10, r_big11, r_neg11;
    logic signed [66:0]     r_sp;
    logic signed [35:0]     n_s;
    logic signed [31:0]     n_sl;
    logic                   n_ovf;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        r_dx <= 33'(i_query_x) - 33'(i_mid_x);
        r_dy <= 33'(i_query_y) - 33'(i_mid_y);
        r_nx <= i_normal_x;
        r_ny <= i_normal_y;
        r_h1 <= i_panel_length[30:1];

        r_p1 <= 51'(r_dx) * 51'(r_nx);
        r_p2 <= 51'(r_dy) * 51'(r_ny);
        r_p3 <= 51'(r_dy) * 51'(r_nx);
        r_p4 <= 51'(r_dx) * 51'(r_ny);
        r_h2 <= r_h1;

        r_dlt3 <= DW'((52'(r_p1) + 52'(r_p2)) >>> FRAC_BITS);
        r_s0   <= UW'((52'(r_p3) - 52'(r_p4)) >>> FRAC_BITS);
        r_h3   <= r_h2;

        r_u1   <= r_s0 + UW'($signed({1'b0, r_h3}));
        r_u2   <= r_s0 - UW'($signed({1'b0, r_h3}));
        r_dlt4 <= r_dlt3;
    end

    // Two end points, each through its own CORDIC and log pipeline.
    pik_cordic #(.IN_W(XW), .STEPS(CORDIC_STEPS)) u_cordic1 (
        .i_clk (i_clk),
        .i_x   ($signed({r_u1, {PRE_SHIFT{1'b0}}})),
        .i_y   ($signed({UW'(r_dlt4), {PRE_SHIFT{1'b0}}})),
        .o_ang (w_a1),
        .o_mag (w_m1)
    );

    pik_cordic #(.IN_W(XW), .STEPS(CORDIC_STEPS)) u_cordic2 (
        .i_clk (i_clk),
        .i_x   ($signed({r_u2, {PRE_SHIFT{1'b0}}})),
        .i_y   ($signed({UW'(r_dlt4), {PRE_SHIFT{1'b0}}})),
        .o_ang (w_a2),
        .o_mag (w_m2)
    );

    pik_ln #(.MAG_W(MW), .FRAC_BITS(FRAC_BITS)) u_ln1 (
        .i_clk (i_clk),
        .i_mag (w_m1),
        .o_lnr (w_l1)
    );

    pik_ln #(.MAG_W(MW), .FRAC_BITS(FRAC_BITS)) u_ln2 (
        .i_clk (i_clk),
        .i_mag (w_m2),
        .o_lnr (w_l2)
    );

    always_ff @(posedge i_clk) begin
        r_d_dlt[0] <= r_dlt4;
        r_d_u1[0]  <= r_u1;
        r_d_u2[0]  <= r_u2;
        for (int k = 1; k < LD; k++) begin
            r_d_dlt[k] <= r_d_dlt[k-1];
            r_d_u1[k]  <= r_d_u1[k-1];
            r_d_u2[k]  <= r_d_u2[k-1];
        end
        r_d_a1[0] <= w_a1;
        r_d_a2[0] <= w_a2;
        for (int k = 1; k < LN_LAT; k++) begin
            r_d_a1[k] <= r_d_a1[k-1];
            r_d_a2[k] <= r_d_a2[k-1];
        end
    end

    // Angle differences and the aligned operands of the final sum.
    always_ff @(posedge i_clk) begin
        r_diff  <= AW1'(r_d_a1[LN_LAT-1]) - AW1'(r_d_a2[LN_LAT-1]);
        r_ndiff <= AW1'(r_d_a2[LN_LAT-1]) - AW1'(r_d_a1[LN_LAT-1]);
        r_ud5   <= (UW+1)'(r_d_u1[LD-1]) - (UW+1)'(r_d_u2[LD-1]);
        r_dlt5  <= r_d_dlt[LD-1];
        r_u15   <= r_d_u1[LD-1];
        r_u25   <= r_d_u2[LD-1];
        r_l15   <= w_l1;
        r_l25   <= w_l2;
    end

    // The wide products but r_dd are split into a low and a high partial product.
    always_ff @(posedge i_clk) begin
        r_p0l <= P0LW'(r_dlt5) * P0LW'($signed({1'b0, r_diff[SPLIT-1:0]}));
        r_p0h <= P0HW'(r_dlt5) * P0HW'(r_diff >>> SPLIT);
        r_p1l <= P1LW'(r_u15) * P1LW'($signed({1'b0, r_l15[SPLIT-1:0]}));
        r_p1h <= P1HW'(r_u15) * P1HW'(r_l15 >>> SPLIT);
        r_p2l <= P1LW'(r_u25) * P1LW'($signed({1'b0, r_l25[SPLIT-1:0]}));
        r_p2h <= P1HW'(r_u25) * P1HW'(r_l25 >>> SPLIT);
        r_dd  <= DDW'(r_ndiff) * DDW'($signed({1'b0, INV2PI_Q31}));
        r_ud6 <= r_ud5;
    end

    always_comb begin
        n_dsum = r_dd + (DDW'(1) <<< (60 - FRAC_BITS));
        n_dl   = n_dsum >>> (61 - FRAC_BITS);
        if (n_dl > DDW'(S_MAX)) begin
            n_dl32 = 32'sh7FFFFFFF;
        end else if (n_dl < DDW'(S_MIN)) begin
            n_dl32 = -32'sh80000000;
        end else begin
            n_dl32 = n_dl[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0  <= (NW'(r_p0h) <<< SPLIT) + NW'(r_p0l);
        r_m1  <= (NW'(r_p1h) <<< SPLIT) + NW'(r_p1l);
        r_m2  <= (NW'(r_p2h) <<< SPLIT) + NW'(r_p2l);
        r_t   <= NW'(r_ud6) <<< 30;
        r_dl7 <= n_dl32;

        r_sa  <= r_m0 + r_t + (NW'(1) <<< 29);
        r_sb  <= r_m2 - r_m1;
        r_dl8 <= r_dl7;

        r_n   <= r_sa + r_sb;
        r_dl9 <= r_dl8;
    end

    // Back to Q.F with the half already added, then range check.
    assign n_v = $signed(r_n[NW-1:30]);

    always_ff @(posedge i_clk) begin
        r_v     <= n_v[35:0];
        r_big10 <= (n_v > V_LIM) || (n_v < -V_LIM);
        r_neg10 <= r_n[NW-1];
        r_dl10  <= r_dl9;

        r_sp    <= 67'(r_v) * 67'($signed({1'b0, INV2PI_Q31}));
        r_big11 <= r_big10;
        r_neg11 <= r_neg10;
        r_dl11  <= r_dl10;
    end

    assign n_s = 36'((r_sp + (67'(1) <<< 30)) >>> 31);

    always_comb begin
        n_ovf = 1'b0;
        if (r_big11) begin
            n_ovf = 1'b1;
            n_sl  = r_neg11 ? -32'sh80000000 : 32'sh7FFFFFFF;
        end else if (n_s > S_MAX) begin
            n_ovf = 1'b1;
            n_sl  = 32'sh7FFFFFFF;
        end else if (n_s < S_MIN) begin
            n_ovf = 1'b1;
            n_sl  = -32'sh80000000;
        end else begin
            n_sl  = n_s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_single_layer <= n_sl;
        o_double_layer <= r_dl11;
        o_overflow     <= n_ovf;
    end

`ifndef SYNTHESIS
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted item produced no result after the pipeline latency");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a matching accepted item");

    a_overflow_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_single_layer == 32'sh7FFFFFFF || o_single_layer == -32'sh80000000))
        else $error("overflow flagged on an unsaturated single-layer result");
`endif

endmodule
